// File: src/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Hysteresis pump thermostat package
// Shared widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  // Stream payload widths.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Field widths of the register file.
  localparam int unsigned BAND_W     = 11;
  localparam int unsigned SECONDS_W  = 16;
  localparam int unsigned MS_W       = 26;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned PIDX_W     = 2;

  // Milliseconds per second, used to scale the second-based limits.
  localparam logic [9:0] MS_PER_S = 10'd1000;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_S = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SW_S   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_MASK  = 3'd6;

  // Input opcodes carried on tuser.
  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_MANUAL   = 1'b1;

  // Bit positions of the result tdata.
  localparam int unsigned OUT_ON_BIT   = 2;
  localparam int unsigned OUT_SW_BIT   = 3;
  localparam int unsigned OUT_HELD_BIT = 4;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the input transfer
    logic eval;   // compute held and band flags, rewind the pump index
    logic step;   // advance to the next pump
    logic emit;   // update the current pump and load the result register
  } hpt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic masked;    // current pump is selected by the mask
    logic idx_last;  // current pump is the last one visited
    logic out_free;  // result register can take a new result this cycle
  } hpt_sts_t;

endpackage

`default_nettype wire

// File: src/hpt_ctrl.sv
// ----------------------------------------------------------------------------
// Hysteresis pump thermostat controller
// Sequences accept, evaluate and the per-pump visit of one evaluate item.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_ctrl
  import hpt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_valid_i,
  input  wire logic     s_opcode_i,
  output logic          s_ready_o,
  output hpt_cmd_t      cmd_o,
  input  wire hpt_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_VISIT
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          if (s_opcode_i == OP_EVALUATE) begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_VISIT;
      end
      S_VISIT: begin
        if (!sts_i.masked || sts_i.out_free) begin
          cmd_o.emit = sts_i.masked;
          cmd_o.step = 1'b1;
          if (sts_i.idx_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only written when the result register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result written while the result register is occupied");

  // An accepted evaluate item always moves on to evaluation.
  a_eval_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && s_opcode_i == OP_EVALUATE) |=> (state_q == S_EVAL))
    else $error("evaluate item not followed by evaluation");

  // No input is taken while pumps are still being visited.
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && (cmd_o.step || cmd_o.eval)))
    else $error("input captured during evaluation");

endmodule

`default_nettype wire

// File: src/hpt_dp.sv
// ----------------------------------------------------------------------------
// Hysteresis pump thermostat datapath
// Register file, pump state, band and timing compares, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_dp
  import hpt_pkg::*;
#(
  parameter int unsigned NUM_PUMPS = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [IN_DATA_W-1:0]   in_data_i,
  input  wire logic                   in_opcode_i,
  input  wire hpt_cmd_t               cmd_i,
  output hpt_sts_t                    sts_o,
  output logic                        out_valid_o,
  output logic [OUT_DATA_W-1:0]       out_data_o,
  output logic                        out_last_o,
  input  wire logic                   out_ready_i
);

  // Only pumps below both NUM_PUMPS and the mask width are visited.
  localparam int unsigned NUM_VISIT = (NUM_PUMPS < MASK_W) ? NUM_PUMPS : MASK_W;
  localparam int unsigned IDX_W     = (NUM_VISIT > 1) ? $clog2(NUM_VISIT) : 1;
  localparam logic [MASK_W-1:0] VISIT_MASK = MASK_W'((1 << NUM_VISIT) - 1);

  // Configuration registers.
  logic signed [TEMP_W-1:0]    setpoint_q;
  logic [BAND_W-1:0]           band_q;
  logic                        heat_q;
  logic                        auto_q;
  logic [SECONDS_W-1:0]        ovr_s_q;
  logic [SECONDS_W-1:0]        min_s_q;
  logic [MASK_W-1:0]           mask_q;
  logic [MS_W-1:0]             ovr_ms_q;
  logic [MS_W-1:0]             min_ms_q;

  // Item and pump state.
  logic [TIME_W-1:0]           manual_q;
  logic [TIME_W-1:0]           now_q;
  logic signed [TEMP_W-1:0]    temp_q;
  logic                        held_q;
  logic                        turn_on_q;
  logic                        turn_off_q;
  logic [IDX_W-1:0]            idx_q;
  logic [NUM_VISIT-1:0]        pump_q;
  logic [TIME_W-1:0]           chg_q [NUM_VISIT];

  // Result register.
  logic                        out_valid_q;
  logic [OUT_DATA_W-1:0]       out_data_q;
  logic                        out_last_q;

  // Combinational terms.
  logic signed [TEMP_W+2:0]    t2, s2, lo2, hi2;
  logic                        held_d, above_c, below_c;
  logic [TIME_W-1:0]           ovr_elapsed, sw_elapsed;
  logic [PIDX_W-1:0]           pidx;
  logic [MASK_W-1:0]           vis_mask;
  logic                        cur_on, new_on, sw_c, may_on, last_c;

  assign t2  = $signed({{2{temp_q[TEMP_W-1]}}, temp_q, 1'b0});
  assign s2  = $signed({{2{setpoint_q[TEMP_W-1]}}, setpoint_q, 1'b0});
  assign lo2 = s2 - $signed({4'b0, band_q});
  assign hi2 = s2 + $signed({4'b0, band_q});
  assign above_c = (t2 > hi2);
  assign below_c = (t2 < lo2);

  assign ovr_elapsed = now_q - manual_q;
  assign held_d = !auto_q ||
                  ((manual_q != '0) && (ovr_elapsed <= {6'b0, ovr_ms_q}));

  assign pidx     = PIDX_W'(idx_q);
  assign vis_mask = mask_q & VISIT_MASK;
  assign last_c   = ((vis_mask >> pidx) >> 1) == '0;
  assign cur_on   = pump_q[idx_q];
  assign sw_elapsed = now_q - chg_q[idx_q];
  assign may_on   = sw_elapsed > {6'b0, min_ms_q};

  always_comb begin
    new_on = cur_on;
    sw_c   = 1'b0;
    if (!held_q) begin
      if (turn_off_q) begin
        new_on = 1'b0;
        sw_c   = cur_on;
      end else if (turn_on_q && may_on) begin
        new_on = 1'b1;
        sw_c   = !cur_on;
      end
    end
  end

  assign sts_o.masked   = vis_mask[pidx];
  assign sts_o.idx_last = (idx_q == IDX_W'(NUM_VISIT - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  // Register file and the scaled millisecond limits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= 12'sd320;
      band_q     <= 11'd16;
      heat_q     <= 1'b1;
      auto_q     <= 1'b0;
      ovr_s_q    <= '0;
      min_s_q    <= '0;
      mask_q     <= '0;
      ovr_ms_q   <= '0;
      min_ms_q   <= '0;
    end else begin
      ovr_ms_q <= MS_W'(ovr_s_q) * MS_W'(MS_PER_S);
      min_ms_q <= MS_W'(min_s_q) * MS_W'(MS_PER_S);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SETPOINT:   setpoint_q <= $signed(cfg_data_i[TEMP_W-1:0]);
          REG_BAND:       band_q     <= cfg_data_i[BAND_W-1:0];
          REG_HEAT_MODE:  heat_q     <= cfg_data_i[0];
          REG_AUTO_EN:    auto_q     <= cfg_data_i[0];
          REG_OVERRIDE_S: ovr_s_q    <= cfg_data_i[SECONDS_W-1:0];
          REG_MIN_SW_S:   min_s_q    <= cfg_data_i[SECONDS_W-1:0];
          REG_PUMP_MASK:  mask_q     <= cfg_data_i[MASK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Captured item fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q  <= in_data_i[TIME_W-1:0];
      temp_q <= $signed(in_data_i[TIME_W+TEMP_W-1:TIME_W]);
    end
    if (cmd_i.eval) begin
      held_q     <= held_d;
      turn_off_q <= heat_q ? above_c : below_c;
      turn_on_q  <= heat_q ? below_c : above_c;
    end
    if (cmd_i.emit) begin
      out_data_q <= OUT_DATA_W'({held_q, sw_c, new_on, pidx});
      out_last_q <= last_c;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q    <= '0;
      idx_q       <= '0;
      pump_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_VISIT; i++) begin
        chg_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load && in_opcode_i == OP_MANUAL) begin
        manual_q <= in_data_i[TIME_W-1:0];
      end
      if (cmd_i.eval) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.emit) begin
        pump_q[idx_q] <= new_on;
        if (sw_c) begin
          chg_q[idx_q] <= now_q;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A pump reported as held was not switched.
  a_held_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[OUT_HELD_BIT] && out_data_q[OUT_SW_BIT]))
    else $error("held pump reported as switched");

endmodule

`default_nettype wire

// File: src/hysteresis_pump_thermostat.sv
// ----------------------------------------------------------------------------
// Hysteresis pump thermostat
// Bang-bang thermostat with a manual override timeout and a shared minimum
// switch time, driving up to four masked pumps.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Contents
// s_axis    in         tvalid/tready         tdata: now_ms, temperature
//                                            tuser: opcode
// m_axis    out        tvalid/tready         tdata: pump_index, pump_on,
//                                            switched, held; tlast: last_result
// cfg       in         cfg_we_i (no wait)    cfg_idx_i selects, cfg_data_i
//
// A manual-command transfer gives no result. An evaluate transfer is first
// accepted, then the band and override are evaluated, and then each of the
// min(NUM_PUMPS, 4) visited pumps is taken in turn, walking over the pump
// state registers. The block takes the next transfer once the last pump is
// visited, even if a result still waits in the output register. A stalled
// output freezes the pump walk at the next masked pump. After reset every
// pump is off, no manual command is recorded and the registers hold their
// documented defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_pump_thermostat
  import hpt_pkg::*;
#(
  parameter int unsigned NUM_PUMPS = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  // Configuration writes.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,

  // Input items.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [31:0] now_ms, [43:32] temperature, [47:44] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  wire logic                  s_axis_tuser,

  // Result items.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [1:0] pump_index, [2] pump_on, [3] switched, [4] held, [7:5] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast
);

  hpt_cmd_t cmd;
  hpt_sts_t sts;

  // The controller owns the input handshake and the pump walk sequence.
  hpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_opcode_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The datapath holds the registers, the pump state and the result register.
  hpt_dp #(
    .NUM_PUMPS (NUM_PUMPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_opcode_i (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

`default_nettype wire
